/* rtl/id_range_slot_allocator_assert.svh */
// Assertion macros used by the slot allocator top level.
// Depends on nothing; included by id_range_slot_allocator.sv.
// Each macro drops out when SYNTHESIS is defined.
`ifndef ID_RANGE_SLOT_ALLOCATOR_ASSERT_SVH
`define ID_RANGE_SLOT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off while reset is low.
`define IRSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("irsa assertion failed");

// Next-cycle implication, held off while reset is low.
`define IRSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("irsa assertion failed");

`else

`define IRSA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IRSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/irsa_pkg.sv */
// Package of the id range slot allocator: sizes, command and status codes.
// Used by the channel interfaces, the free slot search and the top level.
package irsa_pkg;

  localparam int SLOTS      = 64;
  localparam int VALUE_BITS = 32;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int ID_W       = 16;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_BAD_CFG = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_START = 2'd0,
    REG_RANGE_END   = 2'd1
  } reg_idx_e;

  // Result of the lowest free slot search.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } free_hit_t;

endpackage

/* rtl/irsa_in_if.sv */
// Command channel of the slot allocator: valid/ready plus the command word.
// Depends on irsa_pkg for field widths.
interface irsa_in_if;
  import irsa_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [ID_W-1:0]   ident;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, cmd, ident, data_in, input ready);
  modport sink   (input valid, cmd, ident, data_in, output ready);
endinterface

/* rtl/irsa_out_if.sv */
// Result channel of the slot allocator: valid/ready plus the result word.
// Depends on irsa_pkg for field widths.
interface irsa_out_if;
  import irsa_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ID_W-1:0]   ident_out;
  logic [DATA_W-1:0] data_out;
  logic [CNT_W-1:0]  free_count;

  modport source (output valid, status, ident_out, data_out, free_count, input ready);
  modport sink   (input valid, status, ident_out, data_out, free_count, output ready);
endinterface

/* rtl/id_range_slot_allocator.sv */
// Id range slot allocator.
//
// Channels: in_if takes command words (cmd, ident, data_in); out_if returns
// one result word (status, ident_out, data_out, free_count) per command.
// Both use valid/ready; a word moves when valid and ready are high at a
// rising edge. Registers range_start (index 0) and range_end (index 1) are
// written through cfg_we_i/cfg_idx_i/cfg_data_i, by the user only while the
// block is idle (the block does not enforce it); each write frees every slot.
// Latency: the result is valid in the cycle after the command is taken.
// Throughput: one command per cycle while out_if is not stalled. Values sit
// in a 64 x 32 memory with a registered read; the used bits are flip-flops so
// the lowest free slot is found in the cycle of the command, and each
// command's write lands before the next command's read.
// Stall: while a result waits, a new command is taken only in the cycle the
// receiver takes the waiting result, so ready falls while out_if is stalled.
// Reset: all slots free, range 0..63, no result pending. The value memory is
// not cleared; a slot's value is only returned after it has been written.
// Depends on irsa_pkg, irsa_in_if, irsa_out_if, irsa_free_search and the
// assertion macro header.
`include "id_range_slot_allocator_assert.svh"

module id_range_slot_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [irsa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [irsa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  irsa_in_if.sink                        in_if,
  irsa_out_if.source                     out_if
);
  import irsa_pkg::*;

  logic [ID_W-1:0]       start_q, end_q;
  logic [SLOTS-1:0]      used_q, used_d;
  logic [CNT_W-1:0]      used_cnt_q, used_cnt_d;
  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [ID_W-1:0]       ident_q, ident_d;
  logic [CNT_W-1:0]      free_q, free_d;
  logic                  get_hit_q, get_hit_d;
  logic [VALUE_BITS-1:0] rd_q;
  logic [VALUE_BITS-1:0] mem [SLOTS];

  logic                  accept;
  logic                  cfg_hit;
  logic [ID_W:0]         diff;
  logic                  span_ok;
  logic [CNT_W-1:0]      span;
  logic [ID_W-1:0]       offset;
  logic [SLOT_W-1:0]     lk_slot;
  logic                  lk_hit;
  free_hit_t             free_hit;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_slot;

  assign accept  = in_if.valid && in_if.ready;
  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i == REG_RANGE_START || cfg_idx_i == REG_RANGE_END);

  // Span check: end below start, or more identifiers than slots, is bad.
  assign diff    = {1'b0, end_q} - {1'b0, start_q};
  assign span_ok = (end_q >= start_q) && (diff < (ID_W+1)'(SLOTS));
  assign span    = span_ok ? CNT_W'(diff + 1'b1) : '0;

  assign offset  = in_if.ident - start_q;
  assign lk_slot = offset[SLOT_W-1:0];
  assign lk_hit  = span_ok && (in_if.ident >= start_q) && (in_if.ident <= end_q) &&
                   used_q[lk_slot];

  irsa_free_search u_free_search (
    .used_i (used_q),
    .span_i (span),
    .hit_o  (free_hit)
  );

  always_comb begin
    used_d     = used_q;
    used_cnt_d = used_cnt_q;
    status_d   = ST_MISS;
    ident_d    = in_if.ident;
    get_hit_d  = 1'b0;
    wr_en      = 1'b0;
    wr_slot    = free_hit.slot;
    if (!span_ok) begin
      status_d = ST_BAD_CFG;
    end else begin
      unique case (cmd_e'(in_if.cmd))
        CMD_ADD: begin
          if (free_hit.found) begin
            status_d              = ST_OK;
            ident_d               = start_q + ID_W'(free_hit.slot);
            used_d[free_hit.slot] = 1'b1;
            used_cnt_d            = used_cnt_q + 1'b1;
            wr_en                 = 1'b1;
          end
        end
        CMD_GET: begin
          if (lk_hit) begin
            status_d  = ST_OK;
            get_hit_d = 1'b1;
          end
        end
        CMD_UPDATE: begin
          if (lk_hit) begin
            status_d = ST_OK;
            wr_en    = 1'b1;
            wr_slot  = lk_slot;
          end
        end
        CMD_REMOVE: begin
          if (lk_hit) begin
            status_d        = ST_OK;
            used_d[lk_slot] = 1'b0;
            used_cnt_d      = used_cnt_q - 1'b1;
          end
        end
        default: begin
          status_d = ST_MISS;
        end
      endcase
    end
    free_d = span_ok ? (span - used_cnt_d) : '0;
  end

  // Control state; a range write frees every slot and wins over a command's slot update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      end_q       <= ID_W'(SLOTS - 1);
      used_q      <= '0;
      used_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_hit) begin
        if (cfg_idx_i == REG_RANGE_START) begin
          start_q <= cfg_data_i;
        end else begin
          end_q <= cfg_data_i;
        end
        used_q     <= '0;
        used_cnt_q <= '0;
      end else if (accept) begin
        used_q     <= used_d;
        used_cnt_q <= used_cnt_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word; held while the receiver stalls since no command is taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      ident_q   <= ident_d;
      free_q    <= free_d;
      get_hit_q <= get_hit_d;
    end
  end

  // Value memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem[wr_slot] <= in_if.data_in[VALUE_BITS-1:0];
    end
    if (accept) begin
      rd_q <= mem[lk_slot];
    end
  end

  assign in_if.ready       = !out_valid_q || out_if.ready;
  assign out_if.valid      = out_valid_q;
  assign out_if.status     = status_q;
  assign out_if.ident_out  = ident_q;
  assign out_if.free_count = free_q;
  assign out_if.data_out   = get_hit_q ? DATA_W'(rd_q) : '0;

  `IRSA_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, used_cnt_q <= CNT_W'(SLOTS))
  `IRSA_ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, accept, !out_valid_q || out_if.ready)
  `IRSA_ASSERT_NEXT(a_cfg_clear, clk_i, rst_ni, cfg_hit, used_cnt_q == '0 && used_q == '0)
  `IRSA_ASSERT_NEXT(a_add_count, clk_i, rst_ni,
    accept && !cfg_hit && span_ok && in_if.cmd == CMD_ADD && free_hit.found,
    used_cnt_q == CNT_W'($past(used_cnt_q) + 1'b1))

endmodule

/* rtl/irsa_free_search.sv */
// Lowest free slot search over the used bits, limited to the configured span.
// Depends on irsa_pkg for SLOTS, widths and free_hit_t.
module irsa_free_search (
  input  logic [irsa_pkg::SLOTS-1:0] used_i,
  input  logic [irsa_pkg::CNT_W-1:0] span_i,
  output irsa_pkg::free_hit_t        hit_o
);
  import irsa_pkg::*;

  logic [SLOTS-1:0] avail;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      avail[i] = !used_i[i] && (CNT_W'(i) < span_i);
    end
  end

  // Scan from the top so the lowest free slot wins.
  always_comb begin
    hit_o.found = |avail;
    hit_o.slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        hit_o.slot = SLOT_W'(i);
      end
    end
  end

endmodule
